// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CRCFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== rtl/crcfr_pkg.sv =====
package crcfr_pkg;

  // Item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes
  localparam logic ST_GOOD    = 1'b0;
  localparam logic ST_CRC_ERR = 1'b1;

  // Framing constants
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_INIT    = 8'h00;
  localparam logic [4:0] POS_BODY    = 5'd2;
  localparam logic [4:0] POS_LAST    = 5'd31;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam int unsigned NUM_TARGETS = 6;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } crcfr_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] target_a;
    logic signed [31:0] target_b;
    logic signed [31:0] target_c;
    logic signed [31:0] target_d;
    logic signed [31:0] target_e;
    logic signed [31:0] target_f;
    logic [31:0]        speed_bits;
    logic [7:0]         move_mode;
  } crcfr_result_t;

  typedef logic [15:0] crcfr_cfg_t;

  // One CRC-8 byte step, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcfr_chan_if.sv =====
// Valid/ready channel carrying one payload per request.
interface crcfr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/crcfr_in_stage.sv =====
// Input register: holds one item until the parser takes it.
module crcfr_in_stage import crcfr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  crcfr_chan_if.sink     in_i,
  input  logic           item_take_i,
  output logic           item_valid_o,
  output crcfr_item_t    item_o
);

  logic        valid_q;
  crcfr_item_t item_q;

  // free slot, or the held item leaves this cycle
  assign in_i.ready = !valid_q || item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.payload;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/crcfr_parser.sv =====
// Frame state machine, running CRC, field stores and quiet-time counter.
module crcfr_parser import crcfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  crcfr_chan_if.sink    cfg_i,
  input  logic          item_valid_i,
  input  crcfr_item_t   item_i,
  output logic          item_take_o,
  input  logic          res_free_i,
  output logic          res_load_o,
  output crcfr_result_t res_o
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_SYNC2 = 3'b010,
    PH_BODY  = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [16:0] quiet_q, quiet_d;
  logic [15:0] timeout_q;

  logic [31:0] target_q [NUM_TARGETS];
  logic [31:0] speed_q;
  logic [7:0]  mode_q;

  logic        emit;
  logic        tgt_we, spd_we, mode_we;
  logic [4:0]  rel;
  logic [2:0]  tgt_word;
  logic [1:0]  tgt_lane, spd_lane;
  logic [7:0]  b;

  assign b   = item_i.data_byte;
  assign rel = pos_q - POS_BODY;
  assign tgt_word = rel[4:2];
  assign tgt_lane = rel[1:0];
  assign spd_lane = 2'(pos_q - 5'd26);

  // timeout register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.payload;
    end
  end

  // next-state logic for one item
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    quiet_d = quiet_q;
    emit    = 1'b0;
    tgt_we  = 1'b0;
    spd_we  = 1'b0;
    mode_we = 1'b0;
    if (item_i.command == CMD_TICK) begin
      quiet_d = (quiet_q == '1) ? quiet_q : quiet_q + 17'd1;
      if ((phase_q == PH_SYNC2 || phase_q == PH_BODY) && quiet_d > {1'b0, timeout_q}) begin
        phase_d = PH_HUNT;
        pos_d   = '0;
        crc_d   = CRC_INIT;
      end
    end else begin
      quiet_d = '0;
      case (phase_q)
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            crc_d   = crc8_step(crc_q, b);
            pos_d   = POS_BODY;
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_HUNT;
            pos_d   = '0;
            crc_d   = CRC_INIT;
          end
        end
        PH_BODY: begin
          if (pos_q != POS_LAST) begin
            crc_d = crc8_step(crc_q, b);
            pos_d = pos_q + 5'd1;
            case (pos_q) inside
              [5'd2:5'd25]:  tgt_we  = 1'b1;
              [5'd26:5'd29]: spd_we  = 1'b1;
              5'd30:         mode_we = 1'b1;
              default:       ;
            endcase
          end else begin
            emit    = 1'b1;
            phase_d = PH_HUNT;
            pos_d   = '0;
            crc_d   = CRC_INIT;
          end
        end
        default: begin
          // hunting for the first sync byte
          if (b == SYNC_FIRST) begin
            crc_d   = crc8_step(CRC_INIT, b);
            pos_d   = 5'd1;
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_HUNT;
            pos_d   = '0;
            crc_d   = CRC_INIT;
          end
        end
      endcase
    end
  end

  // a frame end waits until the result register has room
  assign item_take_o = item_valid_i && (!emit || res_free_i);
  assign res_load_o  = item_valid_i && emit && res_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      crc_q   <= CRC_INIT;
      quiet_q <= '0;
    end else if (item_take_o) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      quiet_q <= quiet_d;
    end
  end

  // field stores, one byte lane per body byte
  always_ff @(posedge clk_i) begin
    if (item_take_o && tgt_we) begin
      target_q[tgt_word][tgt_lane*8 +: 8] <= b;
    end
    if (item_take_o && spd_we) begin
      speed_q[spd_lane*8 +: 8] <= b;
    end
    if (item_take_o && mode_we) begin
      mode_q <= b;
    end
  end

  // result as seen on the CRC byte
  always_comb begin
    res_o.status     = (crc_q == b) ? ST_GOOD : ST_CRC_ERR;
    res_o.target_a   = signed'(target_q[0]);
    res_o.target_b   = signed'(target_q[1]);
    res_o.target_c   = signed'(target_q[2]);
    res_o.target_d   = signed'(target_q[3]);
    res_o.target_e   = signed'(target_q[4]);
    res_o.target_f   = signed'(target_q[5]);
    res_o.speed_bits = speed_q;
    res_o.move_mode  = mode_q;
  end

endmodule

// ===== rtl/crcfr_res_stage.sv =====
// Result register: holds a frame result until the consumer takes it.
module crcfr_res_stage import crcfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_load_i,
  input  crcfr_result_t res_i,
  output logic          res_free_o,
  crcfr_chan_if.source  res_o
);

  logic          valid_q;
  crcfr_result_t res_q;

  assign res_free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = res_q;

endmodule

// ===== rtl/crc8_checked_frame_receiver_core.sv =====
// Channel | Dir | Payload                                       | Request moves
// in_i    | in  | command, data_byte                            | one byte or one tick
// cfg_i   | in  | timeout_ticks (16 bit)                        | one register write
// res_o   | out | status, target_a..f, speed_bits, move_mode    | one checked frame
//
// One item per cycle unless a frame end waits on a stalled result; an item
// passes the input register, the parser logic and lands in the result
// register, which holds a frame result once its CRC byte has passed through.
// Reset clears the frame state, quiet counter and both valid flags; the
// timeout comes up as 50 ticks. A stalled result holds only a frame-end
// item in the input register; bytes and ticks keep flowing otherwise.
module crc8_checked_frame_receiver_core import crcfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  crcfr_chan_if.sink    in_i,
  crcfr_chan_if.sink    cfg_i,
  crcfr_chan_if.source  res_o
);

  logic          item_valid;
  logic          item_take;
  crcfr_item_t   item;
  logic          res_free;
  logic          res_load;
  crcfr_result_t res_next;

  crcfr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_take_i  (item_take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  crcfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_free_i   (res_free),
    .res_load_o   (res_load),
    .res_o        (res_next)
  );

  crcfr_res_stage u_res (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_load_i (res_load),
    .res_i      (res_next),
    .res_free_o (res_free),
    .res_o      (res_o)
  );

endmodule

// ===== rtl/crcfr_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the frame receiver.
module crcfr_checker import crcfr_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input crcfr_result_t out_payload_i
);

  // a fresh result follows an accepted CRC byte through the input and result registers
  `CRCFR_ASSERT_IMP(a_res_after_byte, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

  // input back-pressure only while a result is stuck at the output
  `CRCFR_ASSERT_IMP(a_no_false_stall, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

  // a stalled result stays put
  `CRCFR_ASSERT_NXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))

endmodule

bind crc8_checked_frame_receiver_core crcfr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);

// ===== test/crc8_checked_frame_receiver_core_test.sv =====
`timescale 1ns / 1ps

module crc8_checked_frame_receiver_core_test;
  import crcfr_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST  = 3'b001,
    HUNT_SECOND = 3'b010,
    IN_BODY     = 3'b100
  } hunt_phase_e;

  localparam logic [16:0] QUIET_SAT   = 17'h1FFFF;
  localparam int          LONG_STALL  = 400;
  localparam int          PHASE_ITEMS = 180;

  logic clk_i = 1'b0;
  logic rst_ni;

  crcfr_chan_if #(.payload_t(crcfr_item_t))   in_ch ();
  crcfr_chan_if #(.payload_t(crcfr_cfg_t))    cfg_ch ();
  crcfr_chan_if #(.payload_t(crcfr_result_t)) res_ch ();

  crc8_checked_frame_receiver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored by the checker
  hunt_phase_e  m_phase;
  logic [4:0]   m_pos;
  logic [7:0]   m_crc;
  logic [31:0]  m_targets [NUM_TARGETS];
  logic [31:0]  m_speed;
  logic [7:0]   m_mode;
  logic [16:0]  m_quiet;
  logic [15:0]  m_timeout;

  crcfr_item_t   pending_q [$];
  crcfr_result_t checked_frames_q [$];
  int unsigned   queued_count;
  int unsigned   fail_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            stall_left;
  logic          stall_kick;

  // CRC-8, polynomial 0x07, fed MSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ b[i]) ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic void restart_hunt();
    m_phase = HUNT_FIRST;
    m_pos   = '0;
    m_crc   = CRC_INIT;
  endfunction

  // Advance the mirrored parser by one accepted request
  function automatic void parse_item(input crcfr_item_t it);
    logic [4:0]    rel;
    crcfr_result_t r;
    if (it.command == CMD_TICK) begin
      if (m_quiet != QUIET_SAT) m_quiet = m_quiet + 17'd1;
      if (m_phase != HUNT_FIRST && m_quiet > {1'b0, m_timeout}) restart_hunt();
      return;
    end
    m_quiet = '0;
    case (m_phase)
      HUNT_SECOND: begin
        if (it.data_byte == SYNC_SECOND) begin
          m_crc   = crc8_shift(m_crc, it.data_byte);
          m_pos   = POS_BODY;
          m_phase = IN_BODY;
        end else begin
          restart_hunt();
        end
      end
      IN_BODY: begin
        if (m_pos != POS_LAST) begin
          if (m_pos <= 5'd25) begin
            rel = m_pos - POS_BODY;
            m_targets[rel[4:2]][rel[1:0]*8 +: 8] = it.data_byte;
          end else if (m_pos <= 5'd29) begin
            rel = m_pos - 5'd26;
            m_speed[rel[1:0]*8 +: 8] = it.data_byte;
          end else begin
            m_mode = it.data_byte;
          end
          m_crc = crc8_shift(m_crc, it.data_byte);
          m_pos = m_pos + 5'd1;
        end else begin
          r.status     = (m_crc == it.data_byte) ? ST_GOOD : ST_CRC_ERR;
          r.target_a   = m_targets[0];
          r.target_b   = m_targets[1];
          r.target_c   = m_targets[2];
          r.target_d   = m_targets[3];
          r.target_e   = m_targets[4];
          r.target_f   = m_targets[5];
          r.speed_bits = m_speed;
          r.move_mode  = m_mode;
          checked_frames_q.push_back(r);
          restart_hunt();
        end
      end
      default: begin
        if (it.data_byte == SYNC_FIRST) begin
          m_crc   = crc8_shift(CRC_INIT, it.data_byte);
          m_pos   = 5'd1;
          m_phase = HUNT_SECOND;
        end else begin
          restart_hunt();
        end
      end
    endcase
  endfunction

  function automatic void check_frame(input crcfr_result_t got, input crcfr_result_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.target_a !== want.target_a) begin
      $error("target_a: expected %0d, got %0d", want.target_a, got.target_a);
      fail_count++;
    end
    if (got.target_b !== want.target_b) begin
      $error("target_b: expected %0d, got %0d", want.target_b, got.target_b);
      fail_count++;
    end
    if (got.target_c !== want.target_c) begin
      $error("target_c: expected %0d, got %0d", want.target_c, got.target_c);
      fail_count++;
    end
    if (got.target_d !== want.target_d) begin
      $error("target_d: expected %0d, got %0d", want.target_d, got.target_d);
      fail_count++;
    end
    if (got.target_e !== want.target_e) begin
      $error("target_e: expected %0d, got %0d", want.target_e, got.target_e);
      fail_count++;
    end
    if (got.target_f !== want.target_f) begin
      $error("target_f: expected %0d, got %0d", want.target_f, got.target_f);
      fail_count++;
    end
    if (got.speed_bits !== want.speed_bits) begin
      $error("speed_bits: expected %0h, got %0h", want.speed_bits, got.speed_bits);
      fail_count++;
    end
    if (got.move_mode !== want.move_mode) begin
      $error("move_mode: expected %0h, got %0h", want.move_mode, got.move_mode);
      fail_count++;
    end
  endfunction

  // Byte and tick request sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_item(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.payload <= pending_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_kick) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Frame result receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (checked_frames_q.size() == 0) begin
          $error("frame result with none outstanding");
          fail_count++;
        end else begin
          check_frame(res_ch.payload, checked_frames_q.pop_front());
        end
      end
      res_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    crcfr_item_t it;
    it.command   = CMD_BYTE;
    it.data_byte = b;
    pending_q.push_back(it);
    queued_count++;
  endtask

  task automatic queue_ticks(input int unsigned n);
    crcfr_item_t it;
    repeat (n) begin
      it.command   = CMD_TICK;
      it.data_byte = 8'($urandom);
      pending_q.push_back(it);
      queued_count++;
    end
  endtask

  // One 32-byte frame; ticks may be slipped in before byte tick_at, and
  // the frame may be cut short after cut_at bytes
  task automatic queue_frame(input logic [5:0][31:0] tgt, input logic [31:0] spd,
                             input logic [7:0] mode, input bit bad_crc,
                             input int tick_at, input int unsigned tick_n,
                             input int cut_at);
    logic [7:0] fb [32];
    logic [7:0] crc;
    fb[0] = SYNC_FIRST;
    fb[1] = SYNC_SECOND;
    for (int p = 2; p < 26; p++) fb[p] = tgt[(p - 2) / 4][((p - 2) % 4) * 8 +: 8];
    for (int p = 26; p < 30; p++) fb[p] = spd[(p - 26) * 8 +: 8];
    fb[30] = mode;
    crc = CRC_INIT;
    for (int p = 0; p < 31; p++) crc = crc8_shift(crc, fb[p]);
    fb[31] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
    for (int p = 0; p < 32 && p < cut_at; p++) begin
      if (p == tick_at) queue_ticks(tick_n);
      queue_byte(fb[p]);
    end
  endtask

  // Wait for every request to go in and every frame result to come out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_ch.valid || checked_frames_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= v;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    m_timeout = v;
  endtask

  initial begin
    logic [5:0][31:0] tgt;
    logic [7:0]       b;
    int unsigned      phase_start;
    int unsigned      pick;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    res_ch.ready   = 1'b0;
    stall_kick     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queued_count   = 0;
    fail_count     = 0;
    restart_hunt();
    for (int k = 0; k < NUM_TARGETS; k++) m_targets[k] = '0;
    m_speed   = '0;
    m_mode    = '0;
    m_quiet   = '0;
    m_timeout = TIMEOUT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, sync faults, timeouts at the reset setting
    queue_ticks(3);
    tgt = {32'h1234_5678, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF};
    queue_frame(tgt, 32'hFFFF_FFFF, 8'hFF, 1'b0, -1, 0, 32);
    queue_frame('0, 32'd0, 8'h00, 1'b0, -1, 0, 32);
    tgt = {32'h7FFF_FFFF, 32'h8000_0000, 32'h55AA_55AA, 32'hAA55_AA55, 32'd0, 32'hFFFF_FFFF};
    queue_frame(tgt, 32'h8000_0001, 8'hAA, 1'b1, -1, 0, 32);
    // second sync wrong: a repeated 0xAA is not taken as a fresh start
    queue_byte(SYNC_FIRST);
    queue_byte(SYNC_FIRST);
    queue_byte(SYNC_SECOND);
    queue_frame(tgt, 32'h0000_FFFF, 8'h55, 1'b0, -1, 0, 32);
    queue_byte(SYNC_FIRST);
    queue_byte(8'h00);
    queue_frame(tgt, 32'hFFFF_0000, 8'h01, 1'b0, -1, 0, 32);
    // quiet gap right at the limit keeps the frame, one more drops it
    queue_frame(tgt, 32'h0F0F_0F0F, 8'h80, 1'b0, 10, 50, 32);
    queue_frame(tgt, 32'hF0F0_F0F0, 8'h7F, 1'b0, 10, 51, 32);
    queue_frame(tgt, 32'h0, 8'h3C, 1'b0, 1, 51, 32);
    queue_frame(tgt, 32'h1, 8'hC3, 1'b0, 1, 50, 32);
    queue_frame(tgt, 32'h2, 8'h5A, 1'b0, 31, 50, 32);
    queue_frame(tgt, 32'h3, 8'hA5, 1'b1, 31, 51, 32);
    wait_drained();

    // Zero timeout: any tick inside a frame drops it
    write_timeout(16'd0);
    queue_frame(tgt, 32'h4, 8'h11, 1'b0, 5, 1, 32);
    queue_frame(tgt, 32'h5, 8'h22, 1'b0, 5, 0, 32);
    queue_ticks(2);
    queue_frame(tgt, 32'h6, 8'h33, 1'b0, -1, 0, 32);
    wait_drained();

    // Widest timeout: a long quiet gap inside a frame is still tolerated
    write_timeout(16'hFFFF);
    queue_frame(tgt, 32'h7, 8'h44, 1'b0, 20, 100, 32);
    queue_frame(tgt, 32'h9, 8'h77, 1'b0, -1, 0, 32);

    // Random traffic under the four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      pick = $urandom_range(3);
      case (pick)
        0:       write_timeout(16'd0);
        1:       write_timeout(16'($urandom_range(1, 8)));
        2:       write_timeout(TIMEOUT_RESET);
        default: write_timeout(16'($urandom_range(9, 40)));
      endcase
      send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 33 : 0;
      phase_start = queued_count;
      while (queued_count - phase_start < PHASE_ITEMS) begin
        for (int k = 0; k < NUM_TARGETS; k++) tgt[k] = $urandom;
        pick = $urandom_range(99);
        if (pick < 55) begin
          queue_frame(tgt, $urandom, 8'($urandom), 1'b0,
                      ($urandom_range(99) < 30) ? int'($urandom_range(1, 31)) : -1,
                      $urandom_range(0, m_timeout), 32);
        end else if (pick < 65) begin
          queue_frame(tgt, $urandom, 8'($urandom), 1'b1, -1, 0, 32);
        end else if (pick < 75) begin
          queue_frame(tgt, $urandom, 8'($urandom), 1'b0, $urandom_range(1, 31),
                      m_timeout + $urandom_range(1, 3), 32);
        end else if (pick < 82) begin
          queue_frame(tgt, $urandom, 8'($urandom), 1'b0, -1, 0, $urandom_range(1, 31));
        end else if (pick < 88) begin
          b = 8'($urandom);
          if (b == SYNC_SECOND) b = SYNC_FIRST;
          queue_byte(SYNC_FIRST);
          queue_byte(b);
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(2))
              0:       queue_byte(SYNC_FIRST);
              1:       queue_byte(SYNC_SECOND);
              default: queue_byte(8'($urandom));
            endcase
          end
        end else begin
          queue_ticks($urandom_range(1, m_timeout + 3));
        end
      end
    end

    // Back-pressure: receiver holds off while frames keep coming
    wait_drained();
    write_timeout(TIMEOUT_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    stall_kick <= 1'b1;
    @(posedge clk_i);
    stall_kick <= 1'b0;
    repeat (8) begin
      for (int k = 0; k < NUM_TARGETS; k++) tgt[k] = $urandom;
      queue_frame(tgt, $urandom, 8'($urandom), 1'($urandom_range(1)), -1, 0, 32);
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
